/* rtl/clt_pkg.sv */
// ----------------------------------------------------------------------------
// clt_pkg
// Types and constants shared by the command line tokenizer modules.
// ----------------------------------------------------------------------------
package clt_pkg;

  // payload widths
  localparam int CHAR_W   = 8;
  localparam int INDEX_W  = 3;
  localparam int START_W  = 6;
  localparam int TYPE_W   = 2;
  localparam int STATUS_W = 3;
  localparam int TOTAL_W  = 4;

  // result queue depth and the most records one byte can cause
  localparam int QUEUE_DEPTH = 8;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int MAX_PER_ITEM = 2;

  // special characters
  localparam logic [CHAR_W-1:0] CH_NUL  = 8'h00;
  localparam logic [CHAR_W-1:0] CH_LF   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR   = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SP   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_DOT  = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_PLUS = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_0    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9    = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UA   = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UZ   = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LA   = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LZ   = 8'h7A;

  // record kinds
  localparam logic KIND_TOKEN = 1'b0;
  localparam logic KIND_LINE  = 1'b1;

  // token types
  localparam logic [TYPE_W-1:0] TT_STRING = 2'd0;
  localparam logic [TYPE_W-1:0] TT_INT    = 2'd1;
  localparam logic [TYPE_W-1:0] TT_REAL   = 2'd2;

  // line status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_LETTER   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DOT      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SIGN     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG = 3'd4;
  localparam logic [STATUS_W-1:0] ST_TOO_MANY = 3'd5;

  // one result record
  typedef struct packed {
    logic                record_kind;
    logic [INDEX_W-1:0]  token_index;
    logic [START_W-1:0]  token_start;
    logic [TYPE_W-1:0]   token_type;
    logic [STATUS_W-1:0] line_status;
    logic [TOTAL_W-1:0]  token_total;
    logic                last_of_run;
  } rec_t;

  // records caused by one byte, in order
  typedef struct packed {
    logic [1:0] count;
    rec_t       rec0;
    rec_t       rec1;
  } push_t;

endpackage

/* rtl/clt_in_if.sv */
// ----------------------------------------------------------------------------
// clt_in_if
// Byte channel into the tokenizer: valid, ready and one character.
// ----------------------------------------------------------------------------
interface clt_in_if;
  import clt_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_byte;

  modport source (output valid, output char_byte, input ready);
  modport sink   (input valid, input char_byte, output ready);

endinterface

/* rtl/clt_out_if.sv */
// ----------------------------------------------------------------------------
// clt_out_if
// Record channel out of the tokenizer: valid, ready and one token or line record.
// ----------------------------------------------------------------------------
interface clt_out_if;
  import clt_pkg::*;

  logic                valid;
  logic                ready;
  logic                record_kind;
  logic [INDEX_W-1:0]  token_index;
  logic [START_W-1:0]  token_start;
  logic [TYPE_W-1:0]   token_type;
  logic [STATUS_W-1:0] line_status;
  logic [TOTAL_W-1:0]  token_total;
  logic                last_of_run;

  modport source (output valid, output record_kind, output token_index,
                  output token_start, output token_type, output line_status,
                  output token_total, output last_of_run, input ready);
  modport sink   (input valid, input record_kind, input token_index,
                  input token_start, input token_type, input line_status,
                  input token_total, input last_of_run, output ready);

endinterface

/* rtl/clt_scan.sv */
// ----------------------------------------------------------------------------
// clt_scan
// Line state and token classifier: takes one registered byte per cycle,
// updates the scan state and forms up to two records.
// ----------------------------------------------------------------------------
module clt_scan #(
  parameter int MAX_LINE_CHARS = 64,
  parameter int MAX_TOKENS     = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          item_v,
  input  logic [clt_pkg::CHAR_W-1:0]    item_byte,
  output clt_pkg::push_t                push
);
  import clt_pkg::*;

  localparam int POS_W = $clog2(MAX_LINE_CHARS);
  localparam int CNT_W = $clog2(MAX_TOKENS + 1);

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_INT  = 2'd1,
    MODE_REAL = 2'd2,
    MODE_STR  = 2'd3
  } mode_t;

  mode_t               mode_r,    mode_nxt;
  logic [STATUS_W-1:0] status_r,  status_nxt;
  logic [POS_W-1:0]    pos_r,     pos_nxt;
  logic [CNT_W-1:0]    tok_r,     tok_nxt;
  logic [START_W-1:0]  start_r,   start_nxt;
  logic                drop_r,    drop_nxt;

  // token record from a closing token's state
  function automatic rec_t token_rec(mode_t m, logic [CNT_W-1:0] t,
                                     logic [START_W-1:0] s);
    rec_t r;
    r             = '0;
    r.record_kind = KIND_TOKEN;
    r.token_index = INDEX_W'(t - 1'b1);
    r.token_start = s;
    r.token_type  = (m == MODE_STR) ? TT_STRING :
                    (m == MODE_REAL) ? TT_REAL : TT_INT;
    return r;
  endfunction

  logic                is_lf, is_sep, is_letter, is_digit, is_dot, is_sign;
  mode_t               mode1;
  logic [STATUS_W-1:0] status1;
  logic [CNT_W-1:0]    tok1;
  logic [START_W-1:0]  start1;
  logic                drop1;
  logic                open_req;
  mode_t               open_mode;
  logic                emit_sep, emit_end, has_tok, line_done, too_long;
  logic [POS_W:0]      pos_inc;
  logic [STATUS_W-1:0] line_stat;
  rec_t                tok_rec, line_rec;

  // character classes
  always_comb begin
    is_lf     = (item_byte == CH_LF);
    is_sep    = (item_byte inside {CH_NUL, CH_CR, CH_SP});
    is_letter = (item_byte inside {[CH_UA:CH_UZ], [CH_LA:CH_LZ]});
    is_digit  = (item_byte inside {[CH_0:CH_9]});
    is_dot    = (item_byte == CH_DOT);
    is_sign   = (item_byte inside {CH_PLUS, CH_MINUS});
  end

  // mode rules for one non-newline byte
  always_comb begin
    mode1     = mode_r;
    status1   = status_r;
    tok1      = tok_r;
    start1    = start_r;
    drop1     = drop_r;
    open_req  = 1'b0;
    open_mode = MODE_INT;
    emit_sep  = 1'b0;
    if (is_sep) begin
      if (mode_r != MODE_NONE) begin
        emit_sep = !drop_r && (tok_r != '0);
        mode1    = MODE_NONE;
        drop1    = 1'b0;
      end
    end else if (is_letter) begin
      if (mode_r == MODE_INT || mode_r == MODE_REAL) begin
        status1 = ST_LETTER;
      end else if (mode_r == MODE_NONE) begin
        open_req  = 1'b1;
        open_mode = MODE_STR;
      end
    end else if (is_digit) begin
      open_req = (mode_r == MODE_NONE);
    end else if (is_dot) begin
      if (mode_r == MODE_INT) begin
        mode1 = MODE_REAL;
      end else if (mode_r != MODE_STR) begin
        status1 = ST_DOT;
      end
    end else if (is_sign) begin
      if (mode_r == MODE_NONE) begin
        open_req = 1'b1;
      end else if (mode_r != MODE_STR) begin
        status1 = ST_SIGN;
      end
    end

    // open a token, or drop it when the line is full of tokens
    if (open_req) begin
      mode1 = open_mode;
      if (tok_r >= CNT_W'(MAX_TOKENS)) begin
        status1 = ST_TOO_MANY;
        drop1   = 1'b1;
      end else begin
        start1 = START_W'(pos_r);
        tok1   = CNT_W'(tok_r + 1'b1);
        drop1  = 1'b0;
      end
    end
  end

  // line end and record assembly
  always_comb begin
    pos_inc   = (POS_W + 1)'(pos_r) + 1'b1;
    too_long  = !is_lf && (pos_inc >= (POS_W + 1)'(MAX_LINE_CHARS));
    line_done = is_lf || too_long;
    line_stat = is_lf ? status_r : ST_TOO_LONG;

    // a line end closes the token that the byte leaves open
    emit_end  = line_done && (mode1 != MODE_NONE) && !drop1 && (tok1 != '0);
    has_tok   = emit_sep || emit_end;
    tok_rec   = emit_sep ? token_rec(mode_r, tok_r, start_r)
                         : token_rec(mode1, tok1, start1);

    line_rec             = '0;
    line_rec.record_kind = KIND_LINE;
    line_rec.line_status = line_stat;
    line_rec.token_total = TOTAL_W'(tok1);
    line_rec.last_of_run = 1'b1;

    push = '0;
    if (item_v) begin
      push.count = {1'b0, has_tok} + {1'b0, line_done};
      push.rec0  = has_tok ? tok_rec : line_rec;
      push.rec0.last_of_run = !(has_tok && line_done);
      push.rec1  = line_rec;
    end
  end

  // next line state
  always_comb begin
    mode_nxt   = mode_r;
    status_nxt = status_r;
    pos_nxt    = pos_r;
    tok_nxt    = tok_r;
    start_nxt  = start_r;
    drop_nxt   = drop_r;
    if (item_v) begin
      if (line_done) begin
        mode_nxt   = MODE_NONE;
        status_nxt = ST_OK;
        pos_nxt    = '0;
        tok_nxt    = '0;
        start_nxt  = '0;
        drop_nxt   = 1'b0;
      end else begin
        mode_nxt   = mode1;
        status_nxt = status1;
        pos_nxt    = POS_W'(pos_inc);
        tok_nxt    = tok1;
        start_nxt  = start1;
        drop_nxt   = drop1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_NONE;
      status_r <= ST_OK;
      pos_r    <= '0;
      tok_r    <= '0;
      start_r  <= '0;
      drop_r   <= 1'b0;
    end else begin
      mode_r   <= mode_nxt;
      status_r <= status_nxt;
      pos_r    <= pos_nxt;
      tok_r    <= tok_nxt;
      start_r  <= start_nxt;
      drop_r   <= drop_nxt;
    end
  end

`ifndef SYNTHESIS
  // two records from one byte are always a token followed by its line end
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (push.count == 2'd2) |->
      (push.rec0.record_kind == KIND_TOKEN && push.rec1.record_kind == KIND_LINE))
    else $error("clt_scan: two records not token then line");

  // a finished line leaves the line state cleared
  a_line_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (item_v && line_done) |=> (pos_r == '0 && tok_r == '0 && mode_r == MODE_NONE))
    else $error("clt_scan: line state not cleared after line end");
`endif

endmodule

/* rtl/clt_queue.sv */
// ----------------------------------------------------------------------------
// clt_queue
// Small result queue: takes up to two records per cycle, hands out one.
// ----------------------------------------------------------------------------
module clt_queue (
  input  logic                              clk,
  input  logic                              rst_n,
  input  clt_pkg::push_t                    push,
  input  logic                              pop,
  output logic                              head_v,
  output clt_pkg::rec_t                     head,
  output logic [clt_pkg::QUEUE_CNT_W-1:0]   level
);
  import clt_pkg::*;

  rec_t                   slot_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wp_r, wp_nxt;
  logic [QUEUE_PTR_W-1:0] rp_r, rp_nxt;
  logic [QUEUE_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [QUEUE_PTR_W-1:0] wp_plus1;
  logic                   do_pop;

  // pointer and level update
  always_comb begin
    do_pop   = pop && (cnt_r != '0);
    wp_plus1 = QUEUE_PTR_W'(wp_r + 1'b1);
    wp_nxt   = QUEUE_PTR_W'(wp_r + push.count);
    rp_nxt   = do_pop ? QUEUE_PTR_W'(rp_r + 1'b1) : rp_r;
    cnt_nxt  = QUEUE_CNT_W'(cnt_r + push.count - {1'b0, do_pop});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // record storage
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      slot_r[wp_r] <= push.rec0;
    end
    if (push.count == 2'd2) begin
      slot_r[wp_plus1] <= push.rec1;
    end
  end

  assign head_v = (cnt_r != '0);
  assign head   = slot_r[rp_r];
  assign level  = cnt_r;

`ifndef SYNTHESIS
  // pushes never overrun the queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push.count != 2'd0) |->
      ((QUEUE_CNT_W + 1)'(cnt_r) + push.count <= (QUEUE_CNT_W + 1)'(QUEUE_DEPTH)))
    else $error("clt_queue: record pushed into a full queue");

  // level follows pushes and pops
  a_level_track: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (cnt_r == QUEUE_CNT_W'($past(cnt_r) + $past(push.count)
                      - {1'b0, $past(pop) && ($past(cnt_r) != '0)})))
    else $error("clt_queue: level out of step with pushes and pops");
`endif

endmodule

/* rtl/command_line_tokenizer.sv */
// ----------------------------------------------------------------------------
// command_line_tokenizer
// Splits a byte stream into command line tokens and reports a record for
// each closed token and for each finished line.
// ----------------------------------------------------------------------------
//  channel   dir   handshake      payload
//  in_chr    in    valid/ready    char_byte
//  out_rec   out   valid/ready    record_kind, token_index, token_start,
//                                 token_type, line_status, token_total,
//                                 last_of_run
//
//  one byte per cycle is taken while in_chr.ready is high; a byte is registered,
//  scanned in the next cycle and its zero, one or two records enter an
//  eight-entry result queue. records leave at one per cycle; in_chr.ready
//  drops when the queue might not hold the staged byte's records plus two
//  more, which happens only when the output port holds records back. a
//  byte's records reach out_rec through the input register and the queue.
//  rst_n is synchronous: it clears the line state and empties the queue.
// ----------------------------------------------------------------------------
module command_line_tokenizer #(
  parameter int MAX_LINE_CHARS = 64,
  parameter int MAX_TOKENS     = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  clt_in_if.sink    in_chr,
  clt_out_if.source out_rec
);
  import clt_pkg::*;

  logic                   stg_v_r, stg_v_nxt;
  logic [CHAR_W-1:0]      stg_byte_r, stg_byte_nxt;
  logic                   in_take;
  logic [QUEUE_CNT_W:0]   committed;
  push_t                  push;
  rec_t                   head;
  logic                   head_v;
  logic [QUEUE_CNT_W-1:0] level;

  // room for the staged byte's records plus two more
  always_comb begin
    committed = (QUEUE_CNT_W + 1)'(level)
              + (stg_v_r ? (QUEUE_CNT_W + 1)'(MAX_PER_ITEM) : '0);
    in_chr.ready = (committed <= (QUEUE_CNT_W + 1)'(QUEUE_DEPTH - MAX_PER_ITEM));
    in_take      = in_chr.valid && in_chr.ready;
    stg_v_nxt    = in_take;
    stg_byte_nxt = in_take ? in_chr.char_byte : stg_byte_r;
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else begin
      stg_v_r <= stg_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stg_byte_r <= stg_byte_nxt;
  end

  clt_scan #(
    .MAX_LINE_CHARS (MAX_LINE_CHARS),
    .MAX_TOKENS     (MAX_TOKENS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_v    (stg_v_r),
    .item_byte (stg_byte_r),
    .push      (push)
  );

  clt_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .pop    (out_rec.ready),
    .head_v (head_v),
    .head   (head),
    .level  (level)
  );

  // result channel
  assign out_rec.valid       = head_v;
  assign out_rec.record_kind = head.record_kind;
  assign out_rec.token_index = head.token_index;
  assign out_rec.token_start = head.token_start;
  assign out_rec.token_type  = head.token_type;
  assign out_rec.line_status = head.line_status;
  assign out_rec.token_total = head.token_total;
  assign out_rec.last_of_run = head.last_of_run;

endmodule
